/* hdl/kgp_pkg.sv */
// Package for the knob level and gesture preset block.
// Holds constants, codes and the state/item/result/config structs; no dependencies.
package kgp_pkg;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgDataW = 5;

  localparam logic [LevelW-1:0] TopLevel    = 8'd250;
  localparam logic [LevelW-1:0] BottomLevel = 8'd5;
  localparam logic [LevelW-1:0] ApplyDelta  = 8'd5;
  localparam logic [LevelW-1:0] LevelReset  = 8'd255;
  localparam logic [TimeW-1:0]  GestureWin  = 32'd4000;
  localparam logic [CountW-1:0] MaxPresets  = 5'd16;
  localparam logic [CountW-1:0] NumPresetsReset = 5'd8;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef enum logic {
    REG_CONTROL_ENABLE = 1'b0,
    REG_NUM_PRESETS    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LevelW-1:0] applied_level;
    logic [TimeW-1:0]  high_edge_time;
    logic [TimeW-1:0]  low_edge_time;
    logic              at_high;
    logic              at_low;
    logic [IndexW-1:0] preset_now;
  } state_t;

  typedef struct packed {
    logic [SampleW-1:0] adc_sample;
    logic [TimeW-1:0]   time_ms;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] brightness_level;
    logic              brightness_changed;
    logic [IndexW-1:0] preset_index;
    step_t             preset_step;
  } result_t;

  typedef struct packed {
    logic              control_enable;
    logic [CountW-1:0] num_presets;
  } cfg_t;

endpackage

/* hdl/kgp_in_if.sv */
// Input channel: one potentiometer sample with its millisecond timestamp.
// Depends on kgp_pkg for field widths.
interface kgp_in_if;
  logic                         valid;
  logic                         ready;
  logic [kgp_pkg::SampleW-1:0]  adc_sample;
  logic [kgp_pkg::TimeW-1:0]    time_ms;

  modport source (output valid, output adc_sample, output time_ms, input ready);
  modport sink (input valid, input adc_sample, input time_ms, output ready);
endinterface

/* hdl/kgp_out_if.sv */
// Output channel: applied level, change flag, preset index and step code.
// Depends on kgp_pkg for field widths.
interface kgp_out_if;
  logic                        valid;
  logic                        ready;
  logic [kgp_pkg::LevelW-1:0]  brightness_level;
  logic                        brightness_changed;
  logic [kgp_pkg::IndexW-1:0]  preset_index;
  logic [1:0]                  preset_step;

  modport source (output valid, output brightness_level, output brightness_changed,
                  output preset_index, output preset_step, input ready);
  modport sink (input valid, input brightness_level, input brightness_changed,
                input preset_index, input preset_step, output ready);
endinterface

/* hdl/kgp_update.sv */
// Next-state and result logic for one sample: level scaling, gesture
// detection, preset wrap and brightness apply rule. Depends on kgp_pkg.
module kgp_update (
  input  kgp_pkg::state_t  state,
  input  kgp_pkg::item_t   item,
  input  kgp_pkg::cfg_t    cfg,
  output kgp_pkg::state_t  state_next,
  output kgp_pkg::result_t result
);

  logic [kgp_pkg::LevelW-1:0] level;
  logic [kgp_pkg::CountW-1:0] count;
  logic [kgp_pkg::IndexW-1:0] count_m1;
  logic [kgp_pkg::CountW-1:0] index_p1;
  logic                       is_top;
  logic                       is_bottom;
  logic [kgp_pkg::TimeW-1:0]  up_gap;
  logic [kgp_pkg::TimeW-1:0]  down_gap;
  logic                       up_hit;
  logic                       down_hit;
  logic [kgp_pkg::LevelW-1:0] diff;
  logic                       apply;

  // Scale the sample and clamp the preset count into 1..16
  assign level = item.adc_sample[kgp_pkg::SampleW-1 -: kgp_pkg::LevelW];
  always_comb begin
    if (cfg.num_presets == '0) begin
      count = kgp_pkg::CountW'(1);
    end else if (cfg.num_presets > kgp_pkg::MaxPresets) begin
      count = kgp_pkg::MaxPresets;
    end else begin
      count = cfg.num_presets;
    end
  end
  assign count_m1 = kgp_pkg::IndexW'(count - kgp_pkg::CountW'(1));
  assign index_p1 = {1'b0, state.preset_now} + kgp_pkg::CountW'(1);

  // Edge detection; the two regions never overlap
  assign is_top    = level > kgp_pkg::TopLevel;
  assign is_bottom = level < kgp_pkg::BottomLevel;
  assign up_gap    = item.time_ms - state.low_edge_time;
  assign down_gap  = item.time_ms - state.high_edge_time;
  assign up_hit    = is_top && !state.at_high && (up_gap < kgp_pkg::GestureWin)
                     && (item.time_ms != '0) && (state.low_edge_time != '0);
  assign down_hit  = is_bottom && !state.at_low && (down_gap < kgp_pkg::GestureWin)
                     && (item.time_ms != '0) && (state.high_edge_time != '0);

  // Apply the level on a large move or a drop to zero
  assign diff  = (level > state.applied_level) ? level - state.applied_level
                                               : state.applied_level - level;
  assign apply = (diff >= kgp_pkg::ApplyDelta)
                 || (level == '0 && state.applied_level != '0);

  always_comb begin
    state_next          = state;
    result.preset_step  = kgp_pkg::STEP_NONE;
    result.brightness_changed = 1'b0;
    if (cfg.control_enable) begin
      state_next.at_high = is_top;
      state_next.at_low  = is_bottom;
      if (is_top && !state.at_high) begin
        state_next.high_edge_time = item.time_ms;
      end
      if (is_bottom && !state.at_low) begin
        state_next.low_edge_time = item.time_ms;
      end
      if (up_hit) begin
        state_next.preset_now     = (index_p1 >= count) ? '0 : index_p1[kgp_pkg::IndexW-1:0];
        state_next.high_edge_time = '0;
        state_next.low_edge_time  = '0;
        result.preset_step        = kgp_pkg::STEP_UP;
      end else if (down_hit) begin
        state_next.preset_now     = (state.preset_now == '0) ? count_m1
                                    : state.preset_now - kgp_pkg::IndexW'(1);
        state_next.high_edge_time = '0;
        state_next.low_edge_time  = '0;
        result.preset_step        = kgp_pkg::STEP_DOWN;
      end
      if (apply) begin
        state_next.applied_level  = level;
        result.brightness_changed = 1'b1;
      end
    end
    result.brightness_level = state_next.applied_level;
    result.preset_index     = state_next.preset_now;
  end

endmodule

/* hdl/knob_level_and_gesture_preset_top.sv */
// Knob level and gesture preset top level: input register, update logic,
// result register. Depends on kgp_pkg, kgp_in_if, kgp_out_if, kgp_update.
// An accepted item passes the input register, then the state update into the result
// register. Throughput: one item per cycle while the output is not stalled. Reset
// (rst, synchronous) empties both stages, restores level 255, clears edge times,
// flags and index, and sets config to enabled with 8 presets.
module knob_level_and_gesture_preset_top (
  input  logic                          clk,
  input  logic                          rst,
  kgp_in_if.sink                        in_ch,
  kgp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kgp_pkg::CfgDataW-1:0]  cfg_data
);

  kgp_pkg::cfg_t    cfg;
  kgp_pkg::state_t  state;
  kgp_pkg::state_t  state_next;
  kgp_pkg::item_t   in_item;
  kgp_pkg::item_t   in_item_next;
  kgp_pkg::result_t out_res;
  kgp_pkg::result_t res_next;
  logic             in_valid;
  logic             out_valid;
  logic             advance;
  logic             load;

  // Pipeline moves when the result register is free or being drained
  assign advance     = !out_valid || out_ch.ready;
  assign load        = advance && in_valid;
  assign in_ch.ready = !in_valid || advance;
  assign in_item_next.adc_sample = in_ch.adc_sample;
  assign in_item_next.time_ms    = in_ch.time_ms;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_enable <= 1'b1;
      cfg.num_presets    <= kgp_pkg::NumPresetsReset;
    end else if (cfg_we) begin
      case (kgp_pkg::reg_index_t'(cfg_index))
        kgp_pkg::REG_CONTROL_ENABLE: cfg.control_enable <= cfg_data[0];
        kgp_pkg::REG_NUM_PRESETS:    cfg.num_presets    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item <= in_item_next;
    end
  end

  kgp_update u_update (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (res_next)
  );

  // Block state, committed when an item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.applied_level  <= kgp_pkg::LevelReset;
      state.high_edge_time <= '0;
      state.low_edge_time  <= '0;
      state.at_high        <= 1'b0;
      state.at_low         <= 1'b0;
      state.preset_now     <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.brightness_level   = out_res.brightness_level;
  assign out_ch.brightness_changed = out_res.brightness_changed;
  assign out_ch.preset_index       = out_res.preset_index;
  assign out_ch.preset_step        = out_res.preset_step;

  // A preset step clears both edge times
  a_step_clears_edges: assert property (@(posedge clk) disable iff (rst)
    (load && res_next.preset_step != kgp_pkg::STEP_NONE)
    |=> (state.high_edge_time == '0 && state.low_edge_time == '0))
    else $error("edge times not cleared after preset step");

  // A disabled block reports no change and no step
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (load && !cfg.control_enable)
    |=> (!out_ch.brightness_changed && out_ch.preset_step == kgp_pkg::STEP_NONE))
    else $error("disabled block reported an update");

  // Top and bottom regions are never held at once
  a_regions_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(state.at_high && state.at_low))
    else $error("at_high and at_low both set");

  // Reported index matches the committed state
  a_index_tracks_state: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_ch.preset_index == state.preset_now))
    else $error("result index differs from state");

endmodule
